FILE: hw/rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared definitions for the bounded list store
// Field widths, command and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bls_pkg;

    // Default capacity of the store
    localparam int DEPTH_DEF = 16;

    // Field widths of one input item and one result item
    localparam int CMD_W    = 3;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 5;
    localparam int POPPED_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed stream widths, padded to whole bytes
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int OUT_PAD = OUT_W - POPPED_W - STATUS_W - COUNT_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // Class of work a decoded command needs
    typedef enum logic [2:0] {
        KIND_NOP = 3'd0,
        KIND_INS = 3'd1,
        KIND_POP = 3'd2,
        KIND_DEL = 3'd3,
        KIND_REV = 3'd4
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the input item
        logic init;     // set the pointers and latch the status code
        logic rd;       // read the store at the pointers
        logic wr_a;     // move one entry (first half of a swap for reverse)
        logic wr_b;     // second half of a swap
        logic grab;     // capture the front entry as the popped byte
        logic put;      // write the new byte at its slot
        logic len_inc;
        logic len_dec;
        logic finish;   // load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  ok;       // decoded command is legal in the current state
        logic  more;     // the shift or swap loop has another step
        logic  out_free; // the result register can take a new result
    } dp_stat_t;

endpackage

FILE: hw/rtl/bounded_list_store.sv
// Each command is decoded first; push and insert then run a shift loop and store
// the new byte, pop front reads and grabs the head and then runs a shift loop, and
// reverse runs a swap loop. Delete last and ignored or failed commands go straight on.
// One command at a time: the next transfer can come in the cycle after the result
// loads; the shift loop sets the worst case.
// Reset: synchronous, active low; the count clears, entry contents do not.
// ----------------------------------------------------------------------------
// bounded_list_store: ordered byte store with list commands
// Push front or back, insert at a position, pop front, delete last and
// reverse, each returning the popped byte, a status and the new count.
// ----------------------------------------------------------------------------
module bounded_list_store #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command [2:0], value [10:3], position [15:11]
    input  logic [bls_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // popped [7:0], status [9:8], count [14:10], zero [15]
    output logic [bls_pkg::OUT_W-1:0] m_tdata
);
    import bls_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequencer
    bls_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat_i   (dp_stat),
        .cmd_o    (dp_cmd)
    );

    // Storage and result path
    bls_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (dp_cmd),
        .stat_o    (dp_stat),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One command at a time: no transfer directly after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command was in progress");

    // A full status reports a full store
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] == ST_FULL) |-> (m_tdata[14:10] == COUNT_W'(DEPTH)))
        else $error("full status with a count below capacity");

    // An empty status reports no entries and no popped byte
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] == ST_EMPTY) |-> (m_tdata[14:0] == 15'(ST_EMPTY) << 8))
        else $error("empty status with entries or a popped byte");

    // A popped byte only comes with a successful command
    a_popped_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[7:0] != '0) |-> (m_tdata[9:8] == ST_OK))
        else $error("popped byte returned on a failed command");

endmodule

FILE: hw/rtl/bls_datapath.sv
// ----------------------------------------------------------------------------
// bls_datapath: storage, pointers and result register of the list store
// Holds the entry memory, the count, two walking pointers for shifts and
// swaps, the command decode and the result register of the output channel.
// ----------------------------------------------------------------------------
module bls_datapath #(
    parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bls_pkg::dp_cmd_t         cmd_i,
    output bls_pkg::dp_stat_t        stat_o,
    input  logic [bls_pkg::IN_W-1:0] in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [bls_pkg::OUT_W-1:0] out_data
);
    import bls_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    // Captured input item
    logic [CMD_W-1:0]    cmd_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [LW-1:0]       len_reg;
    logic [LW-1:0]       a_reg;
    logic [LW-1:0]       b_reg;
    logic [STATUS_W-1:0] code_reg;
    logic [VAL_W-1:0]    rda_reg;
    logic [VAL_W-1:0]    rdb_reg;
    logic [POPPED_W-1:0] popped_reg;

    logic                out_valid_reg;
    logic [POPPED_W-1:0] res_popped_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic [VAL_W-1:0]    mem [DEPTH];

    // Decode signals
    kind_t               kind;
    logic [STATUS_W-1:0] code;
    logic [LW-1:0]       idx;
    logic [CW-1:0]       pos_x;
    logic [CW-1:0]       len_x;
    logic                is_full;
    logic                no_entries;
    logic                at_front;
    logic                at_append;
    logic                at_middle;

    // Memory access signals
    logic [LW-1:0]       ra_full;
    logic [AW-1:0]       ra;
    logic [AW-1:0]       rb;
    logic                we;
    logic [LW-1:0]       wa_full;
    logic [AW-1:0]       wa;
    logic [VAL_W-1:0]    wd;

    // Command decode against the current count
    always_comb begin
        pos_x      = CW'(pos_reg);
        len_x      = CW'(len_reg);
        is_full    = (len_reg == LW'(DEPTH));
        no_entries = (len_reg == '0);
        at_front   = (pos_reg == POS_W'(1));
        at_append  = (pos_reg != '0) && (pos_x == len_x);
        at_middle  = (pos_reg >= POS_W'(2)) && (pos_x < len_x);
        kind       = KIND_NOP;
        code       = ST_OK;
        idx        = '0;
        case (cmd_reg)
            CMD_PUSH_FRONT: begin
                kind = KIND_INS;
                if (is_full) code = ST_FULL;
            end
            CMD_PUSH_BACK: begin
                kind = KIND_INS;
                idx  = len_reg;
                if (is_full) code = ST_FULL;
            end
            CMD_INSERT: begin
                kind = KIND_INS;
                if (!(at_front || at_append || at_middle)) begin
                    code = ST_BADPOS;
                end else if (is_full) begin
                    code = ST_FULL;
                end
                if (at_front) begin
                    idx = '0;
                end else if (at_append) begin
                    idx = len_reg;
                end else begin
                    idx = LW'(pos_x - CW'(1));
                end
            end
            CMD_POP_FRONT: begin
                kind = KIND_POP;
                if (no_entries) code = ST_EMPTY;
            end
            CMD_DEL_LAST: begin
                kind = KIND_DEL;
                if (no_entries) code = ST_EMPTY;
            end
            CMD_REVERSE: begin
                kind = KIND_REV;
                if (no_entries) code = ST_EMPTY;
            end
            default: begin
                kind = KIND_NOP;
            end
        endcase
    end

    // Status towards the controller
    always_comb begin
        stat_o.kind     = kind;
        stat_o.ok       = (code == ST_OK);
        stat_o.out_free = !out_valid_reg || out_ready;
        case (kind)
            KIND_INS: stat_o.more = (a_reg > b_reg);
            KIND_POP: stat_o.more = (a_reg < len_reg);
            KIND_REV: stat_o.more = (a_reg < b_reg);
            default:  stat_o.more = 1'b0;
        endcase
    end

    // Memory addresses and write data; inserts shift towards the back,
    // pops shift towards the front and reverse swaps the two ends.
    always_comb begin
        ra_full = (kind == KIND_INS) ? (a_reg - LW'(1)) : a_reg;
        ra      = ra_full[AW-1:0];
        rb      = b_reg[AW-1:0];
        we      = cmd_i.wr_a || cmd_i.wr_b || cmd_i.put;
        wa_full = a_reg;
        wd      = rda_reg;
        if (cmd_i.put) begin
            wa_full = b_reg;
            wd      = val_reg;
        end else if (cmd_i.wr_b) begin
            wa_full = b_reg;
            wd      = rda_reg;
        end else begin
            case (kind)
                KIND_POP: wa_full = a_reg - LW'(1);
                KIND_REV: wd      = rdb_reg;
                default:  wa_full = a_reg;
            endcase
        end
        wa = wa_full[AW-1:0];
    end

    // Entry memory with registered reads
    always_ff @(posedge aclk) begin
        if (cmd_i.rd) begin
            rda_reg <= mem[ra];
            rdb_reg <= mem[rb];
        end
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // Input capture, pointers and popped byte
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg    <= in_data[CMD_W-1:0];
            val_reg    <= in_data[CMD_W +: VAL_W];
            pos_reg    <= in_data[CMD_W+VAL_W +: POS_W];
            popped_reg <= '0;
        end
        if (cmd_i.init) begin
            code_reg <= code;
            case (kind)
                KIND_INS: begin
                    a_reg <= len_reg;
                    b_reg <= idx;
                end
                KIND_POP: begin
                    a_reg <= '0;
                end
                KIND_REV: begin
                    a_reg <= '0;
                    b_reg <= len_reg - LW'(1);
                end
                default: begin
                end
            endcase
        end
        if (cmd_i.grab) begin
            popped_reg <= rda_reg;
            a_reg      <= a_reg + LW'(1);
        end
        if (cmd_i.wr_a) begin
            case (kind)
                KIND_INS: a_reg <= a_reg - LW'(1);
                KIND_POP: a_reg <= a_reg + LW'(1);
                default: begin
                end
            endcase
        end
        if (cmd_i.wr_b) begin
            a_reg <= a_reg + LW'(1);
            b_reg <= b_reg - LW'(1);
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cmd_i.len_inc) begin
            len_reg <= len_reg + LW'(1);
        end else if (cmd_i.len_dec) begin
            len_reg <= len_reg - LW'(1);
        end
    end

    // Result register of the output channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.finish) begin
            res_popped_reg <= popped_reg;
            res_status_reg <= code_reg;
            res_count_reg  <= COUNT_W'(len_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{OUT_PAD{1'b0}}, res_count_reg, res_status_reg, res_popped_reg};

endmodule

FILE: hw/rtl/bls_controller.sv
// ----------------------------------------------------------------------------
// bls_controller: sequencer of the list store
// Steps each command through decode, memory reads and writes of the shift
// or swap loop, and the hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module bls_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bls_pkg::dp_stat_t  stat_i,
    output bls_pkg::dp_cmd_t   cmd_o
);
    import bls_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECIDE    = 9'b000000010,
        S_HEAD_RD   = 9'b000000100,
        S_HEAD_GRAB = 9'b000001000,
        S_STEP      = 9'b000010000,
        S_LOOP_RD   = 9'b000100000,
        S_LOOP_WR   = 9'b001000000,
        S_SWAP_WR   = 9'b010000000,
        S_STORE     = 9'b100000000
    } state_t;

    // The wait for a free result register happens in the idle-bound step
    // below, so one more state holds there.
    typedef enum logic [1:0] {
        W_NONE = 2'b01,
        W_WAIT = 2'b10
    } wait_t;

    state_t state_reg, state_next;
    wait_t  wait_reg, wait_next;

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        cmd_o      = '0;
        in_ready   = 1'b0;
        case (wait_reg)
            W_WAIT: begin
                // Finished command waits for the result register
                if (stat_i.out_free) begin
                    cmd_o.finish = 1'b1;
                    wait_next    = W_NONE;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                case (state_reg)
                    S_IDLE: begin
                        in_ready = 1'b1;
                        if (in_valid) begin
                            cmd_o.load = 1'b1;
                            state_next = S_DECIDE;
                        end
                    end
                    S_DECIDE: begin
                        cmd_o.init = 1'b1;
                        if (!stat_i.ok) begin
                            wait_next = W_WAIT;
                        end else begin
                            case (stat_i.kind)
                                KIND_INS: state_next = S_STEP;
                                KIND_REV: state_next = S_STEP;
                                KIND_POP: state_next = S_HEAD_RD;
                                KIND_DEL: begin
                                    cmd_o.len_dec = 1'b1;
                                    wait_next     = W_WAIT;
                                end
                                default: wait_next = W_WAIT;
                            endcase
                        end
                    end
                    S_HEAD_RD: begin
                        cmd_o.rd   = 1'b1;
                        state_next = S_HEAD_GRAB;
                    end
                    S_HEAD_GRAB: begin
                        cmd_o.grab = 1'b1;
                        state_next = S_STEP;
                    end
                    S_STEP: begin
                        if (stat_i.more) begin
                            state_next = S_LOOP_RD;
                        end else begin
                            case (stat_i.kind)
                                KIND_INS: state_next = S_STORE;
                                KIND_POP: begin
                                    cmd_o.len_dec = 1'b1;
                                    wait_next     = W_WAIT;
                                end
                                default: wait_next = W_WAIT;
                            endcase
                        end
                    end
                    S_LOOP_RD: begin
                        cmd_o.rd   = 1'b1;
                        state_next = S_LOOP_WR;
                    end
                    S_LOOP_WR: begin
                        cmd_o.wr_a = 1'b1;
                        state_next = (stat_i.kind == KIND_REV) ? S_SWAP_WR : S_STEP;
                    end
                    S_SWAP_WR: begin
                        cmd_o.wr_b = 1'b1;
                        state_next = S_STEP;
                    end
                    S_STORE: begin
                        cmd_o.put     = 1'b1;
                        cmd_o.len_inc = 1'b1;
                        wait_next     = W_WAIT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wait_reg  <= W_NONE;
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

FILE: sim/bounded_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_store_tb: self-checking testbench for the bounded list store
// A queue of list commands feeds a clocked stream driver. A shadow copy of
// the list predicts every result, and a clocked monitor compares each result
// transfer, field by field, with the oldest prediction. Both sides of the
// stream idle at random, and there are stretches where neither side idles.
// ----------------------------------------------------------------------------
module bounded_list_store_tb;

    import bls_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int N_ITEMS     = 1350;
    localparam int TAIL_CYCLES = 80;

    // Command codes that the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // One queued command; hold_off makes the driver wait for every result first
    typedef struct {
        logic              hold_off;
        logic [IN_W-1:0]   word;
    } list_cmd_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    list_cmd_t         cmd_queue[$];
    logic [OUT_W-1:0]  expected_results[$];

    // Shadow list used for prediction
    logic [7:0]        shadow_mem[DEPTH];
    int                shadow_len = 0;

    // Length as the generator sees it, to steer well-formed sequences
    int                gen_len = 0;

    list_cmd_t         cur_cmd;
    logic              holding = 1'b0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                n_sent = 0;
    int                n_checked = 0;
    int                n_errors = 0;
    int                n_full = 0;
    int                n_empty = 0;
    int                n_badpos = 0;
    int                max_count = 0;
    int                cycle_count = 0;

    bounded_list_store u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the shadow list and return the packed result.
    function automatic logic [OUT_W-1:0] list_apply(input logic [IN_W-1:0] word);
        logic [CMD_W-1:0]    cmd;
        logic [VAL_W-1:0]    val;
        logic [POS_W-1:0]    pos;
        logic [7:0]          popped;
        logic [STATUS_W-1:0] status;
        logic [7:0]          tmp;
        logic                do_ins;
        int                  idx;
        cmd    = word[2:0];
        val    = word[10:3];
        pos    = word[15:11];
        popped = '0;
        status = ST_OK;
        do_ins = 1'b0;
        idx    = 0;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (shadow_len >= DEPTH) status = ST_FULL;
                else do_ins = 1'b1;
            end
            CMD_PUSH_BACK: begin
                if (shadow_len >= DEPTH) status = ST_FULL;
                else begin
                    do_ins = 1'b1;
                    idx    = shadow_len;
                end
            end
            CMD_INSERT: begin
                // Position 1 is the front, the count appends, 2..count-1 go in between.
                if (!(pos == 1 || (pos != 0 && pos == shadow_len) ||
                      (pos >= 2 && pos < shadow_len))) begin
                    status = ST_BADPOS;
                end else if (shadow_len >= DEPTH) begin
                    status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    if (pos == 1) idx = 0;
                    else if (pos == shadow_len) idx = shadow_len;
                    else idx = pos - 1;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_len == 0) status = ST_EMPTY;
                else begin
                    popped = shadow_mem[0];
                    for (int k = 1; k < shadow_len; k++) shadow_mem[k-1] = shadow_mem[k];
                    shadow_len--;
                end
            end
            CMD_DEL_LAST: begin
                if (shadow_len == 0) status = ST_EMPTY;
                else shadow_len--;
            end
            CMD_REVERSE: begin
                if (shadow_len == 0) status = ST_EMPTY;
                else begin
                    for (int k = 0; k < shadow_len / 2; k++) begin
                        tmp                         = shadow_mem[k];
                        shadow_mem[k]               = shadow_mem[shadow_len-1-k];
                        shadow_mem[shadow_len-1-k]  = tmp;
                    end
                end
            end
            default: ;
        endcase
        if (do_ins) begin
            for (int k = shadow_len; k > idx; k--) shadow_mem[k] = shadow_mem[k-1];
            shadow_mem[idx] = val;
            shadow_len++;
        end
        return {1'b0, shadow_len[COUNT_W-1:0], status, popped};
    endfunction

    // Queue a command and track the length it leads to.
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos, input logic hold_off);
        list_cmd_t item;
        item.hold_off = hold_off;
        item.word     = {pos, val, cmd};
        cmd_queue.push_back(item);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_len < DEPTH) gen_len++;
            CMD_INSERT:
                if (pos >= 1 && (pos == 1 || pos <= gen_len) && gen_len < DEPTH) gen_len++;
            CMD_POP_FRONT, CMD_DEL_LAST: if (gen_len > 0) gen_len--;
            default: ;
        endcase
    endtask

    // Stream driver: one transfer per queued command, with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            holding  = 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(list_apply(cur_cmd.word));
                n_sent++;
                holding  = 1'b0;
                gap_left = ((n_sent % 300) < 60) ? 0 : $urandom_range(0, 10);
            end
            if (!holding) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].hold_off && expected_results.size() > 0)) begin
                    cur_cmd  = cmd_queue.pop_front();
                    holding  = 1'b1;
                    s_tdata  <= cur_cmd.word;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest prediction.
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ERROR: result with none expected, actual %h", $time, m_tdata);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want[7:0]) begin
                        $display("%0t ERROR popped: expected %0d actual %0d",
                                 $time, want[7:0], m_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_tdata[9:8] !== want[9:8]) begin
                        $display("%0t ERROR status: expected %0d actual %0d",
                                 $time, want[9:8], m_tdata[9:8]);
                        n_errors++;
                    end
                    if (m_tdata[14:10] !== want[14:10]) begin
                        $display("%0t ERROR count: expected %0d actual %0d",
                                 $time, want[14:10], m_tdata[14:10]);
                        n_errors++;
                    end
                    case (want[9:8])
                        ST_FULL:   n_full++;
                        ST_EMPTY:  n_empty++;
                        ST_BADPOS: n_badpos++;
                        default: ;
                    endcase
                    if (int'(want[14:10]) > max_count) max_count = int'(want[14:10]);
                end
                n_checked++;
                stall_left = ((n_checked % 300) < 60) ? 0 : $urandom_range(0, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ERROR: timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("** bounded_list_store: FAILED **");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int mode;
        int burst;
        int r;
        logic [CMD_W-1:0] op;
        logic [POS_W-1:0] pos;

        // Directed: empty-list cases, bad positions and the single-entry repairs.
        queue_cmd(CMD_POP_FRONT,  8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_DEL_LAST,   8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_REVERSE,    8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_INSERT,     8'h11, 5'd0,  1'b0);
        queue_cmd(CMD_INSERT,     8'h22, 5'd2,  1'b0);
        queue_cmd(CMD_PUSH_BACK,  8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_POP_FRONT,  8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_INSERT,     8'hFF, 5'd1,  1'b0);
        queue_cmd(CMD_INSERT,     8'h5A, 5'd1,  1'b0);
        queue_cmd(CMD_INSERT,     8'h77, 5'd2,  1'b0);
        queue_cmd(CMD_PUSH_FRONT, 8'hA5, 5'd31, 1'b0);
        queue_cmd(CMD_INSERT,     8'h3C, 5'd2,  1'b1);
        queue_cmd(CMD_INSERT,     8'h00, 5'd31, 1'b0);
        queue_cmd(CMD_INSERT,     8'h81, 5'd16, 1'b0);
        queue_cmd(CMD_REVERSE,    8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_SPARE_A,    8'hFF, 5'd31, 1'b0);
        queue_cmd(CMD_SPARE_B,    8'h55, 5'd10, 1'b0);
        queue_cmd(CMD_POP_FRONT,  8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_DEL_LAST,   8'h00, 5'd0,  1'b0);
        queue_cmd(CMD_PUSH_BACK,  8'hC3, 5'd0,  1'b0);

        // Random: bursts that fill, drain or mix, with mostly legal positions.
        while (cmd_queue.size() < N_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(15, 40);
            for (int i = 0; i < burst; i++) begin
                r = $urandom_range(0, 99);
                if (mode == 0)
                    op = (r < 30) ? CMD_PUSH_FRONT : (r < 55) ? CMD_PUSH_BACK :
                         (r < 85) ? CMD_INSERT : (r < 92) ? CMD_POP_FRONT :
                         (r < 97) ? CMD_DEL_LAST : CMD_REVERSE;
                else if (mode == 1)
                    op = (r < 10) ? CMD_PUSH_FRONT : (r < 20) ? CMD_PUSH_BACK :
                         (r < 30) ? CMD_INSERT : (r < 60) ? CMD_POP_FRONT :
                         (r < 85) ? CMD_DEL_LAST : CMD_REVERSE;
                else
                    op = (r < 15) ? CMD_PUSH_FRONT : (r < 30) ? CMD_PUSH_BACK :
                         (r < 50) ? CMD_INSERT : (r < 68) ? CMD_POP_FRONT :
                         (r < 83) ? CMD_DEL_LAST : (r < 97) ? CMD_REVERSE :
                         ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
                if ($urandom_range(0, 99) < 75 && gen_len > 0)
                    pos = POS_W'($urandom_range(1, gen_len));
                else if ($urandom_range(0, 4) == 0)
                    pos = POS_W'(gen_len);
                else
                    pos = POS_W'($urandom_range(0, 31));
                queue_cmd(op, VAL_W'($urandom_range(0, 255)), pos,
                          i == 0 && $urandom_range(0, 3) == 0);
            end
        end

        // Hold reset, then release it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() > 0 || holding || expected_results.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run: %0d commands sent, %0d results checked, largest count %0d.",
                 n_sent, n_checked, max_count);
        $display("Statuses seen: %0d full, %0d empty, %0d bad position; %0d mismatches.",
                 n_full, n_empty, n_badpos, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("** bounded_list_store: PASSED **");
        end else begin
            $display("** bounded_list_store: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_datapath.sv
hw/rtl/bls_controller.sv
hw/rtl/bounded_list_store.sv
sim/bounded_list_store_tb.sv
